[design/imu_cal_pkg.sv]
// Shared types, widths and register indexes for the IMU axis calibration block.
`default_nettype none

package imu_cal_pkg;

    localparam int SAMPLE_W  = 16;   // input sample width
    localparam int COEF_W    = 16;   // default coefficient width
    localparam int RESULT_W  = 32;   // calibrated output width
    localparam int TMP_W     = 18;   // rotated intermediate width
    localparam int ROT_FRAC  = 14;   // Q2.14 matrix coefficients
    localparam int LIN_FRAC  = 12;   // Q4.12 linear gain
    localparam int QUAD_FRAC = 28;   // output scale of the gain sum
    localparam int CFG_W     = 48;   // configuration register width
    localparam int CFG_IDX_W = 3;
    localparam int NUM_AXES  = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_BIAS      = 3'd0;
    localparam t_cfg_idx REG_ROT_ROW0  = 3'd1;
    localparam t_cfg_idx REG_ROT_ROW1  = 3'd2;
    localparam t_cfg_idx REG_ROT_ROW2  = 3'd3;
    localparam t_cfg_idx REG_GAIN_LIN  = 3'd4;
    localparam t_cfg_idx REG_GAIN_QUAD = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
    } t_sample;

    typedef struct packed {
        logic signed [RESULT_W-1:0] cal_x;
        logic signed [RESULT_W-1:0] cal_y;
        logic signed [RESULT_W-1:0] cal_z;
        logic                       clipped;
    } t_result;

endpackage

`default_nettype wire

[design/imu_cal_cfg.sv]
// Configuration registers and coefficient field unpacking.
`default_nettype none

module imu_cal_cfg #(
    parameter int COEF_WIDTH = imu_cal_pkg::COEF_W
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  imu_cal_pkg::t_cfg_idx                 i_cfg_addr,
    input  logic [imu_cal_pkg::CFG_W-1:0]         i_cfg_data,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0] o_bias [3],
    output logic signed [COEF_WIDTH-1:0]          o_rot  [3][3],
    output logic signed [COEF_WIDTH-1:0]          o_lin  [3],
    output logic signed [COEF_WIDTH-1:0]          o_quad [3]
);
    import imu_cal_pkg::*;

    // fields of the upper slot may run past bit 47; those bits read as zero
    localparam int EXT_C = (3 * COEF_WIDTH > CFG_W) ? 3 * COEF_WIDTH : CFG_W;
    localparam int EXT_S = (3 * SAMPLE_W > CFG_W) ? 3 * SAMPLE_W : CFG_W;

    localparam logic [63:0] ONE_ROT = 64'd1 << ROT_FRAC;
    localparam logic [63:0] ONE_LIN = 64'd1 << LIN_FRAC;

    localparam logic [CFG_W-1:0] RST_ROT0 = CFG_W'(ONE_ROT);
    localparam logic [CFG_W-1:0] RST_ROT1 = CFG_W'(ONE_ROT << COEF_WIDTH);
    localparam logic [CFG_W-1:0] RST_ROT2 = CFG_W'(ONE_ROT << (2 * COEF_WIDTH));
    localparam logic [CFG_W-1:0] RST_LIN  =
        CFG_W'(ONE_LIN | (ONE_LIN << COEF_WIDTH) | (ONE_LIN << (2 * COEF_WIDTH)));

    logic [CFG_W-1:0] r_bias;
    logic [CFG_W-1:0] r_rot0;
    logic [CFG_W-1:0] r_rot1;
    logic [CFG_W-1:0] r_rot2;
    logic [CFG_W-1:0] r_lin;
    logic [CFG_W-1:0] r_quad;

    logic [EXT_S-1:0] bias_ext;
    logic [EXT_C-1:0] rot_ext [3];
    logic [EXT_C-1:0] lin_ext;
    logic [EXT_C-1:0] quad_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= '0;
            r_rot0 <= RST_ROT0;
            r_rot1 <= RST_ROT1;
            r_rot2 <= RST_ROT2;
            r_lin  <= RST_LIN;
            r_quad <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_BIAS:      r_bias <= i_cfg_data;
                REG_ROT_ROW0:  r_rot0 <= i_cfg_data;
                REG_ROT_ROW1:  r_rot1 <= i_cfg_data;
                REG_ROT_ROW2:  r_rot2 <= i_cfg_data;
                REG_GAIN_LIN:  r_lin  <= i_cfg_data;
                REG_GAIN_QUAD: r_quad <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign bias_ext   = EXT_S'(r_bias);
    assign rot_ext[0] = EXT_C'(r_rot0);
    assign rot_ext[1] = EXT_C'(r_rot1);
    assign rot_ext[2] = EXT_C'(r_rot2);
    assign lin_ext    = EXT_C'(r_lin);
    assign quad_ext   = EXT_C'(r_quad);

    for (genvar j = 0; j < 3; j++) begin : g_col
        assign o_bias[j] = bias_ext[j*SAMPLE_W +: SAMPLE_W];
        assign o_lin[j]  = lin_ext[j*COEF_WIDTH +: COEF_WIDTH];
        assign o_quad[j] = quad_ext[j*COEF_WIDTH +: COEF_WIDTH];
        for (genvar i = 0; i < 3; i++) begin : g_row
            assign o_rot[i][j] = rot_ext[i][j*COEF_WIDTH +: COEF_WIDTH];
        end
    end

endmodule

`default_nettype wire

[design/imu_cal_rot.sv]
// Bias subtract, 3x3 matrix multiply and rounding/saturation to 18 bits.
`default_nettype none

module imu_cal_rot #(
    parameter int COEF_WIDTH = imu_cal_pkg::COEF_W
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  imu_cal_pkg::t_sample                    i_sample,
    input  logic signed [imu_cal_pkg::SAMPLE_W-1:0] i_bias [3],
    input  logic signed [COEF_WIDTH-1:0]            i_rot  [3][3],
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [imu_cal_pkg::TMP_W-1:0]    o_tmp  [3],
    output logic                                    o_clip
);
    import imu_cal_pkg::*;

    localparam int D_W    = SAMPLE_W + 1;
    localparam int PR_W   = D_W + COEF_WIDTH;
    localparam int ACC_W  = PR_W + 2;
    localparam int RQ_W   = ACC_W - ROT_FRAC;
    localparam int CMP_W  = ((RQ_W > TMP_W) ? RQ_W : TMP_W) + 1;

    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (ROT_FRAC - 1);
    localparam logic signed [CMP_W-1:0] TMP_MAX = CMP_W'({(TMP_W-1){1'b1}});
    localparam logic signed [CMP_W-1:0] TMP_MIN = ~TMP_MAX;

    logic signed [SAMPLE_W-1:0] smp [3];

    // stage 1: bias removed
    logic                  r_v1;
    logic signed [D_W-1:0] r_d [3];
    // stage 2: partial products, [row][col]
    logic                   r_v2;
    logic signed [PR_W-1:0] r_prod [3][3];
    // stage 3: rounded, saturated column results
    logic                    r_v3;
    logic signed [TMP_W-1:0] r_tmp [3];
    logic                    r_clip;

    logic rdy1, rdy2, rdy3;

    logic signed [ACC_W-1:0] acc  [3];
    logic signed [RQ_W-1:0]  rq   [3];
    logic signed [CMP_W-1:0] rqx  [3];
    logic signed [TMP_W-1:0] tmp  [3];
    logic [2:0]              sat;

    assign smp[0] = i_sample.sample_x;
    assign smp[1] = i_sample.sample_y;
    assign smp[2] = i_sample.sample_z;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            acc[j] = ACC_W'(r_prod[0][j]) + ACC_W'(r_prod[1][j])
                   + ACC_W'(r_prod[2][j]) + RND;
            rq[j]  = acc[j][ACC_W-1:ROT_FRAC];
            rqx[j] = CMP_W'(rq[j]);
            sat[j] = 1'b0;
            if (rqx[j] > TMP_MAX) begin
                tmp[j] = TMP_MAX[TMP_W-1:0];
                sat[j] = 1'b1;
            end else if (rqx[j] < TMP_MIN) begin
                tmp[j] = TMP_MIN[TMP_W-1:0];
                sat[j] = 1'b1;
            end else begin
                tmp[j] = rqx[j][TMP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= D_W'(smp[i]) - D_W'(i_bias[i]);
            end
        end
        if (rdy2 && r_v1) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= r_d[i] * i_rot[i][j];
                end
            end
        end
        if (rdy3 && r_v2) begin
            r_tmp  <= tmp;
            r_clip <= |sat;
        end
    end

    assign o_valid = r_v3;
    assign o_tmp   = r_tmp;
    assign o_clip  = r_clip;

endmodule

`default_nettype wire

[design/imu_cal_gain.sv]
// Per-axis linear plus quadratic gain, rounding and output saturation.
`default_nettype none

module imu_cal_gain #(
    parameter int COEF_WIDTH = imu_cal_pkg::COEF_W
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic signed [imu_cal_pkg::TMP_W-1:0]     i_tmp  [3],
    input  logic                                     i_clip,
    input  logic signed [COEF_WIDTH-1:0]             i_lin  [3],
    input  logic signed [COEF_WIDTH-1:0]             i_quad [3],
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic signed [imu_cal_pkg::RESULT_W-1:0]  o_cal  [3],
    output logic                                     o_clip
);
    import imu_cal_pkg::*;

    localparam int LP_W  = TMP_W + COEF_WIDTH;     // tmp * lin
    localparam int SQ_W  = 2 * TMP_W - 1;          // tmp * tmp, never negative
    localparam int LO_W  = TMP_W;
    localparam int HI_W  = SQ_W - LO_W;
    localparam int QL_W  = LO_W + 1 + COEF_WIDTH;
    localparam int QH_W  = HI_W + 1 + COEF_WIDTH;
    localparam int P_W   = SQ_W + COEF_WIDTH + 3;
    localparam int RQ_W  = P_W - QUAD_FRAC;
    localparam int CMP_W = ((RQ_W > RESULT_W) ? RQ_W : RESULT_W) + 1;
    localparam int LSH   = QUAD_FRAC - LIN_FRAC;

    localparam logic signed [P_W-1:0]   RND = P_W'(1) << (QUAD_FRAC - 1);
    localparam logic signed [CMP_W-1:0] OUT_MAX = CMP_W'({(RESULT_W-1){1'b1}});
    localparam logic signed [CMP_W-1:0] OUT_MIN = ~OUT_MAX;

    // stage 4
    logic                   r_v4;
    logic signed [LP_W-1:0] r_lp4 [3];
    logic [SQ_W-1:0]        r_sq  [3];
    logic                   r_c4;
    // stage 5: square split in two halves against quad
    logic                   r_v5;
    logic signed [LP_W-1:0] r_lp5 [3];
    logic signed [QL_W-1:0] r_ql  [3];
    logic signed [QH_W-1:0] r_qh  [3];
    logic                   r_c5;
    // stage 6: full sum at 2^-28 scale
    logic                   r_v6;
    logic signed [P_W-1:0]  r_p [3];
    logic                   r_c6;
    // stage 7: output register
    logic                       r_v7;
    logic signed [RESULT_W-1:0] r_cal [3];
    logic                       r_c7;

    logic rdy4, rdy5, rdy6, rdy7;

    logic signed [2*TMP_W-1:0] sq   [3];
    logic signed [P_W-1:0]     ps   [3];
    logic signed [RQ_W-1:0]    rq   [3];
    logic signed [CMP_W-1:0]   rqx  [3];
    logic signed [RESULT_W-1:0] cal [3];
    logic [2:0]                sat;

    assign rdy7    = !r_v7 || i_ready;
    assign rdy6    = !r_v6 || rdy7;
    assign rdy5    = !r_v5 || rdy6;
    assign rdy4    = !r_v4 || rdy5;
    assign o_ready = rdy4;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            sq[j]  = i_tmp[j] * i_tmp[j];
            ps[j]  = r_p[j] + RND;
            rq[j]  = ps[j][P_W-1:QUAD_FRAC];
            rqx[j] = CMP_W'(rq[j]);
            sat[j] = 1'b0;
            if (rqx[j] > OUT_MAX) begin
                cal[j] = OUT_MAX[RESULT_W-1:0];
                sat[j] = 1'b1;
            end else if (rqx[j] < OUT_MIN) begin
                cal[j] = OUT_MIN[RESULT_W-1:0];
                sat[j] = 1'b1;
            end else begin
                cal[j] = rqx[j][RESULT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (rdy4) r_v4 <= i_valid;
            if (rdy5) r_v5 <= r_v4;
            if (rdy6) r_v6 <= r_v5;
            if (rdy7) r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && i_valid) begin
            for (int j = 0; j < 3; j++) begin
                r_lp4[j] <= i_tmp[j] * i_lin[j];
                r_sq[j]  <= sq[j][SQ_W-1:0];
            end
            r_c4 <= i_clip;
        end
        if (rdy5 && r_v4) begin
            for (int j = 0; j < 3; j++) begin
                r_lp5[j] <= r_lp4[j];
                r_ql[j]  <= $signed({1'b0, r_sq[j][LO_W-1:0]}) * i_quad[j];
                r_qh[j]  <= $signed({1'b0, r_sq[j][SQ_W-1:LO_W]}) * i_quad[j];
            end
            r_c5 <= r_c4;
        end
        if (rdy6 && r_v5) begin
            for (int j = 0; j < 3; j++) begin
                r_p[j] <= (P_W'(r_lp5[j]) <<< LSH) + (P_W'(r_qh[j]) <<< LO_W)
                        + P_W'(r_ql[j]);
            end
            r_c6 <= r_c5;
        end
        if (rdy7 && r_v6) begin
            r_cal <= cal;
            r_c7  <= r_c6 | (|sat);
        end
    end

    assign o_valid = r_v7;
    assign o_cal   = r_cal;
    assign o_clip  = r_c7;

endmodule

`default_nettype wire

[design/imu_axis_calibration.sv]
// Top level of the three-axis sensor calibration pipeline.
`default_nettype none

// Calibrates one three-axis sample per item: subtracts the per-axis bias,
// multiplies the differences (as a row vector) by a 3x3 Q2.14 matrix, rounds
// half up and saturates each column to 18 bits, then applies tmp*lin (Q4.12)
// plus tmp*tmp*quad (2^-28 scale), rounds half up and saturates to signed
// 32 bits. clipped is set when any intermediate or output saturated.
// The pipeline takes one item per cycle while the output is not stalled; an
// accepted item reaches the output through the seven register
// stages (bias subtract, matrix products, column sum/round, lin and square
// products, quad products in two halves, gain sum, output round/saturate).
// Each stage holds its item while the next is full, so bubbles close up
// under output stall and nothing is lost or repeated. The design keeps no
// state between items. Configuration registers (index 0 bias, 1..3 matrix
// rows, 4 linear gain, 5 quadratic gain; 48 bits, three fields each, axis x
// in the low bits) are read live by the pipeline, so write them only while
// no item is in flight. Indexes 6 and 7 are ignored.
module imu_axis_calibration #(
    parameter int COEF_WIDTH = imu_cal_pkg::COEF_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  imu_cal_pkg::t_sample          i_in_item,
    // calibrated output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output imu_cal_pkg::t_result          o_out_item,
    // configuration writes
    input  logic                          i_cfg_we,
    input  imu_cal_pkg::t_cfg_idx         i_cfg_addr,
    input  logic [imu_cal_pkg::CFG_W-1:0] i_cfg_data
);
    import imu_cal_pkg::*;

    logic signed [SAMPLE_W-1:0]   bias [3];
    logic signed [COEF_WIDTH-1:0] rot  [3][3];
    logic signed [COEF_WIDTH-1:0] lin  [3];
    logic signed [COEF_WIDTH-1:0] quad [3];

    logic                     rot_ready;
    logic                     mid_valid;
    logic                     mid_ready;
    logic signed [TMP_W-1:0]  mid_tmp [3];
    logic                     mid_clip;
    logic signed [RESULT_W-1:0] cal [3];
    logic                     cal_clip;

    imu_cal_cfg #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_bias     (bias),
        .o_rot      (rot),
        .o_lin      (lin),
        .o_quad     (quad)
    );

    // stages 1..3: bias, matrix, round to 18 bits
    imu_cal_rot #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_rot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (rot_ready),
        .i_sample (i_in_item),
        .i_bias   (bias),
        .i_rot    (rot),
        .o_valid  (mid_valid),
        .i_ready  (mid_ready),
        .o_tmp    (mid_tmp),
        .o_clip   (mid_clip)
    );

    // stages 4..7: gain terms and output saturation
    imu_cal_gain #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_tmp   (mid_tmp),
        .i_clip  (mid_clip),
        .i_lin   (lin),
        .i_quad  (quad),
        .o_valid (o_out_valid),
        .i_ready (!i_out_stall),
        .o_cal   (cal),
        .o_clip  (cal_clip)
    );

    assign o_in_stall = !rot_ready;

    assign o_out_item.cal_x   = cal[0];
    assign o_out_item.cal_y   = cal[1];
    assign o_out_item.cal_z   = cal[2];
    assign o_out_item.clipped = cal_clip;

endmodule

`default_nettype wire
